[rtl/cwes_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coincidence window energy summer package
// Shared widths, register indexes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package cwes_pkg;

    // Number of crystal channels
    localparam int CHANNELS = 12;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int CH_W     = 4;
    localparam int ENERGY_W = 24;
    localparam int TIME_W   = 40;
    localparam int SUM_W    = 32;
    localparam int CFG_W    = 32;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] WINDOW_RESET    = 32'd400000;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 32'd50000;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx LAST_IDX = t_idx'(CHANNELS - 1);

    // Configuration register indexes
    typedef enum logic {
        CFG_WINDOW    = 1'b0,
        CFG_THRESHOLD = 1'b1
    } t_cfg_idx;

    // Input item kinds
    typedef enum logic {
        KIND_HIT = 1'b0,
        KIND_EOE = 1'b1
    } t_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted hit
        logic check;     // window check and reference latch
        logic add;       // accumulate into the channel sum
        logic load;      // load one result into the output register
        logic clear;     // clear sums and reference
        t_idx rd_idx;    // channel being read out
        logic last;      // final result of the event
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free; // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

[rtl/cwes_hit_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hit input channel
// Valid/ready channel carrying one hit or end-of-event item.
// ----------------------------------------------------------------------------
interface cwes_hit_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [cwes_pkg::CH_W-1:0]     channel;
    logic [cwes_pkg::ENERGY_W-1:0] energy_ev;
    logic [cwes_pkg::TIME_W-1:0]   time_ps;

    modport source (output valid, kind, channel, energy_ev, time_ps, input ready);
    modport sink   (input valid, kind, channel, energy_ev, time_ps, output ready);
endinterface

`default_nettype wire

[rtl/cwes_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one per-channel energy sum item.
// ----------------------------------------------------------------------------
interface cwes_res_if;
    logic                       valid;
    logic                       ready;
    logic [cwes_pkg::CH_W-1:0]  out_channel;
    logic [cwes_pkg::SUM_W-1:0] energy_sum_ev;
    logic                       above_threshold;
    logic                       last;

    modport source (output valid, out_channel, energy_sum_ev, above_threshold, last,
                    input ready);
    modport sink   (input valid, out_channel, energy_sum_ev, above_threshold, last,
                    output ready);
endinterface

`default_nettype wire

[rtl/cwes_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coincidence window energy summer controller
// Sequences hit processing and the per-channel readout of an event.
// ----------------------------------------------------------------------------
module cwes_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_kind,
    output logic                  o_in_ready,
    input  wire cwes_pkg::t_sts   i_sts,
    output cwes_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADD,
        ST_EMIT
    } t_state;

    t_state          r_state, n_state;
    cwes_pkg::t_idx  r_cnt, n_cnt;
    logic            accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Decode commands and next state
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.rd_idx = r_cnt;
        o_cmd.last   = (r_cnt == cwes_pkg::LAST_IDX);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_kind == cwes_pkg::KIND_EOE) begin
                        n_state = ST_EMIT;
                        n_cnt   = '0;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.load = 1'b1;
                    if (r_cnt == cwes_pkg::LAST_IDX) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and readout counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/cwes_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coincidence window energy summer datapath
// Channel sums, reference time, window check and the output register.
// ----------------------------------------------------------------------------
module cwes_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [cwes_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [cwes_pkg::CH_W-1:0]     i_channel,
    input  wire logic [cwes_pkg::ENERGY_W-1:0] i_energy_ev,
    input  wire logic [cwes_pkg::TIME_W-1:0]   i_time_ps,
    input  wire cwes_pkg::t_cmd                i_cmd,
    output cwes_pkg::t_sts                     o_sts,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [cwes_pkg::CH_W-1:0]          o_out_channel,
    output logic [cwes_pkg::SUM_W-1:0]         o_energy_sum_ev,
    output logic                               o_above_threshold,
    output logic                               o_last
);

    // Configuration
    logic [cwes_pkg::CFG_W-1:0]    r_window;
    logic [cwes_pkg::CFG_W-1:0]    r_threshold;

    // Event state
    logic [cwes_pkg::SUM_W-1:0]    r_sums [cwes_pkg::CHANNELS];
    logic [cwes_pkg::TIME_W-1:0]   r_ref_time;
    logic                          r_ref_valid;

    // Captured hit
    logic [cwes_pkg::CH_W-1:0]     r_channel;
    logic [cwes_pkg::ENERGY_W-1:0] r_energy;
    logic [cwes_pkg::TIME_W-1:0]   r_time;
    logic                          r_ok;

    // Output register
    logic                          r_out_valid;
    logic [cwes_pkg::CH_W-1:0]     r_out_channel;
    logic [cwes_pkg::SUM_W-1:0]    r_out_sum;
    logic                          r_out_above;
    logic                          r_out_last;

    logic                          in_range;
    logic [cwes_pkg::TIME_W-1:0]   eff_ref;
    logic [cwes_pkg::TIME_W-1:0]   time_gap;
    logic                          in_window;
    cwes_pkg::t_idx                hit_idx;
    logic [cwes_pkg::SUM_W:0]      wide_sum;
    logic [cwes_pkg::SUM_W-1:0]    sat_sum;
    logic [cwes_pkg::SUM_W-1:0]    rd_sum;

    // Window check: first hit of the event is its own reference
    assign in_range  = ({2'b00, r_channel} < 6'(cwes_pkg::CHANNELS));
    assign eff_ref   = r_ref_valid ? r_ref_time : r_time;
    assign time_gap  = (r_time >= eff_ref) ? (r_time - eff_ref) : (eff_ref - r_time);
    assign in_window = (time_gap <= {8'd0, r_window});

    // Saturating accumulate
    assign hit_idx  = cwes_pkg::t_idx'(r_channel);
    assign wide_sum = {1'b0, r_sums[hit_idx]} + {9'd0, r_energy};
    assign sat_sum  = wide_sum[cwes_pkg::SUM_W] ? '1 : wide_sum[cwes_pkg::SUM_W-1:0];

    // Readout
    assign rd_sum          = r_sums[i_cmd.rd_idx];
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= cwes_pkg::WINDOW_RESET;
            r_threshold <= cwes_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cwes_pkg::CFG_WINDOW:    r_window    <= i_cfg_data;
                cwes_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Latch the hit and the window decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_channel <= i_channel;
            r_energy  <= i_energy_ev;
            r_time    <= i_time_ps;
        end
        if (i_cmd.check) begin
            r_ok <= in_range && in_window;
        end
    end

    // Update sums and reference; clear at end of event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int c = 0; c < cwes_pkg::CHANNELS; c++) begin
                r_sums[c] <= '0;
            end
            r_ref_time  <= '0;
            r_ref_valid <= 1'b0;
        end else begin
            if (i_cmd.check && in_range && !r_ref_valid) begin
                r_ref_time  <= r_time;
                r_ref_valid <= 1'b1;
            end
            if (i_cmd.add && r_ok) begin
                r_sums[hit_idx] <= sat_sum;
            end
        end
    end

    // Output register: load a result or drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_channel <= cwes_pkg::CH_W'(i_cmd.rd_idx);
            r_out_sum     <= rd_sum;
            r_out_above   <= (rd_sum > r_threshold);
            r_out_last    <= i_cmd.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_channel     = r_out_channel;
    assign o_energy_sum_ev   = r_out_sum;
    assign o_above_threshold = r_out_above;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire

[rtl/coincidence_window_energy_summer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coincidence window energy summer
// Builds windowed per-channel energy sums for a crystal array event.
// ----------------------------------------------------------------------------
// A hit item passes through accept, window check against the event's
// reference time, then a saturating add into that channel's sum; the next
// item is accepted once the add is done. An accepted end-of-event item
// drives one result per channel, one per cycle while the sink takes them;
// the single output register sets that pace. Sums and the reference are
// cleared with the load of the last result, and the next event's hits may
// enter while that result still waits.
module coincidence_window_energy_summer_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [cwes_pkg::CFG_W-1:0] i_cfg_data,
    cwes_hit_if.sink                        i_hit,
    cwes_res_if.source                      o_res
);

    cwes_pkg::t_cmd cmd;
    cwes_pkg::t_sts sts;

    cwes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_hit.valid),
        .i_in_kind  (i_hit.kind),
        .o_in_ready (i_hit.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cwes_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_channel         (i_hit.channel),
        .i_energy_ev       (i_hit.energy_ev),
        .i_time_ps         (i_hit.time_ps),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_out_channel     (o_res.out_channel),
        .o_energy_sum_ev   (o_res.energy_sum_ev),
        .o_above_threshold (o_res.above_threshold),
        .o_last            (o_res.last)
    );

    // The last result always belongs to the highest channel
    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |->
            (o_res.out_channel == cwes_pkg::CH_W'(cwes_pkg::CHANNELS - 1)))
        else $error("last result not on highest channel");

    // Readout never names a channel that does not exist
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ({2'b00, o_res.out_channel} < 6'(cwes_pkg::CHANNELS)))
        else $error("result channel out of range");

    // An accepted end of event blocks further input while it is read out
    a_eoe_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_hit.valid && i_hit.ready && (i_hit.kind == cwes_pkg::KIND_EOE))
            |=> !i_hit.ready)
        else $error("input accepted during readout");

    // A hit keeps the input closed for its check and add cycles
    a_hit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_hit.valid && i_hit.ready && (i_hit.kind == cwes_pkg::KIND_HIT))
            |=> (!i_hit.ready ##1 !i_hit.ready))
        else $error("input accepted during hit processing");

endmodule

`default_nettype wire

[dv/tb_coincidence_window_energy_summer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coincidence window energy summer testbench
// Drives hit and end-of-event items through the valid/ready channels. It keeps
// a prediction of the per-channel windowed sums and compares every
// result item field by field. The run covers several window and threshold
// settings, random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_coincidence_window_energy_summer_unit;
    import cwes_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SETTLE      = 8;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 8;
    localparam longint unsigned TIME_MAX = 64'h0000_00FF_FFFF_FFFF;

    typedef struct {
        t_kind                 kind;
        logic [CH_W-1:0]       channel;
        logic [ENERGY_W-1:0]   energy;
        logic [TIME_W-1:0]     time_ps;
    } t_hit_item;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [SUM_W-1:0] sum;
        logic             flag;
        logic             last;
    } t_sum_item;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    t_cfg_idx          cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    cwes_hit_if hit_ch ();
    cwes_res_if res_ch ();

    coincidence_window_energy_summer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_hit       (hit_ch),
        .o_res       (res_ch)
    );

    // Predicted block state
    logic [SUM_W-1:0]  chan_sum [CHANNELS];
    logic [TIME_W-1:0] ref_time;
    logic              ref_valid;
    logic [CFG_W-1:0]  window_ps;
    logic [CFG_W-1:0]  threshold_ev;

    t_hit_item pending_hits[$];
    t_sum_item expected_sums[$];

    int  errors;
    int  cycle_count;
    int  phase_items;
    bit  calm;
    bit  hit_fire;
    int  hold_req;
    int  hold_done;
    int  hold_left;

    // Clock and run limit
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Clear sums and the reference time
    function automatic void clear_event();
        for (int c = 0; c < CHANNELS; c++) chan_sum[c] = '0;
        ref_time  = '0;
        ref_valid = 1'b0;
    endfunction

    // Advance the predicted state by one accepted item
    function automatic void sum_energy(t_hit_item it);
        logic [TIME_W-1:0] gap;
        logic [SUM_W:0]    acc;
        t_sum_item         r;
        if (it.kind == KIND_HIT) begin
            if (it.channel < CHANNELS) begin
                if (!ref_valid) begin
                    ref_time  = it.time_ps;
                    ref_valid = 1'b1;
                end
                gap = (it.time_ps >= ref_time) ? it.time_ps - ref_time
                                               : ref_time - it.time_ps;
                if (gap <= TIME_W'(window_ps)) begin
                    acc = {1'b0, chan_sum[it.channel]} + (SUM_W + 1)'(it.energy);
                    chan_sum[it.channel] = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
                end
            end
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                r.channel = CH_W'(c);
                r.sum     = chan_sum[c];
                r.flag    = chan_sum[c] > threshold_ev;
                r.last    = (c == CHANNELS - 1);
                expected_sums.push_back(r);
            end
            clear_event();
        end
    endfunction

    function automatic void check_field(string fname, logic [63:0] exp_v,
                                        logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
        end
    endfunction

    // Predict on accepted hits, then check accepted result items
    always @(posedge i_clk) begin
        t_hit_item it;
        t_sum_item e;
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            it.kind    = t_kind'(hit_ch.kind);
            it.channel = hit_ch.channel;
            it.energy  = hit_ch.energy_ev;
            it.time_ps = hit_ch.time_ps;
            sum_energy(it);
            hit_fire = 1'b1;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_sums.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result item, expected none, actual ch %0d sum %0h",
                         $time, res_ch.out_channel, res_ch.energy_sum_ev);
            end else begin
                e = expected_sums.pop_front();
                check_field("out_channel", e.channel, res_ch.out_channel);
                check_field("energy_sum_ev", e.sum, res_ch.energy_sum_ev);
                check_field("above_threshold", e.flag, res_ch.above_threshold);
                check_field("last", e.last, res_ch.last);
            end
        end
    end

    // Offer the next pending item once the previous one is taken
    always @(negedge i_clk) begin
        t_hit_item nxt;
        if (!i_rst_n) begin
            hit_ch.valid <= 1'b0;
        end else if (!hit_ch.valid || hit_fire) begin
            hit_fire = 1'b0;
            if (pending_hits.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
                nxt = pending_hits.pop_front();
                hit_ch.kind      <= nxt.kind;
                hit_ch.channel   <= nxt.channel;
                hit_ch.energy_ev <= nxt.energy;
                hit_ch.time_ps   <= nxt.time_ps;
                hit_ch.valid     <= 1'b1;
            end else begin
                hit_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= calm || ($urandom_range(99) >= 34);
        end
    end

    task automatic push_hit(logic [CH_W-1:0] ch, logic [ENERGY_W-1:0] en,
                            logic [TIME_W-1:0] t);
        t_hit_item it;
        it.kind    = KIND_HIT;
        it.channel = ch;
        it.energy  = en;
        it.time_ps = t;
        pending_hits.push_back(it);
        phase_items++;
    endtask

    // End of event carries junk in the fields it ignores
    task automatic push_eoe();
        t_hit_item it;
        it.kind    = KIND_EOE;
        it.channel = CH_W'($urandom);
        it.energy  = ENERGY_W'($urandom);
        it.time_ps = TIME_W'({$urandom, $urandom});
        pending_hits.push_back(it);
        phase_items++;
    endtask

    // One event: hits scattered around a base time, then end of event
    task automatic push_event(int n_hits);
        longint unsigned base;
        longint unsigned span;
        longint unsigned off;
        longint unsigned t;
        logic [CH_W-1:0]     ch;
        logic [ENERGY_W-1:0] en;
        case ($urandom_range(7))
            0:       base = $urandom_range(5000);
            1:       base = TIME_MAX - $urandom_range(5000);
            default: base = {$urandom, $urandom} & TIME_MAX;
        endcase
        span = longint'(window_ps) + (longint'(window_ps) >> 2) + 2;
        for (int h = 0; h < n_hits; h++) begin
            off = {$urandom, $urandom} % span;
            if (h == 0 || $urandom_range(5) == 0) off = 0;
            else if ($urandom_range(7) == 0) off = window_ps;
            if ($urandom_range(1)) t = (off > base) ? 0 : base - off;
            else t = (base + off > TIME_MAX) ? TIME_MAX : base + off;
            ch = ($urandom_range(99) < 8) ? CH_W'($urandom_range(15, CHANNELS))
                                          : CH_W'($urandom_range(CHANNELS - 1));
            case ($urandom_range(9))
                0:       en = '0;
                1:       en = '1;
                2, 3, 4, 5: en = ENERGY_W'($urandom_range(60000));
                default: en = ENERGY_W'($urandom);
            endcase
            push_hit(ch, en, TIME_W'(t));
        end
        push_eoe();
    endtask

    // Wait until every item is taken and every result has arrived
    task automatic wait_drained();
        while (pending_hits.size() != 0 || hit_ch.valid || expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW) window_ps = val;
        else threshold_ev = val;
    endtask

    // Random phase: mostly full events, some bare end-of-event noise
    task automatic random_phase(logic [CFG_W-1:0] win, logic [CFG_W-1:0] thr, int n_items);
        wait_drained();
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_THRESHOLD, thr);
        phase_items = 0;
        while (phase_items < n_items) begin
            if ($urandom_range(9) == 0) push_eoe();
            else push_event($urandom_range(1, 10));
        end
    endtask

    // Stimulus
    initial begin
        errors           = 0;
        cycle_count      = 0;
        calm             = 1'b0;
        hit_fire         = 1'b0;
        hold_req         = 0;
        hold_done        = 0;
        hold_left        = 0;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_WINDOW;
        cfg_data         = '0;
        hit_ch.valid     = 1'b0;
        hit_ch.kind      = KIND_HIT;
        hit_ch.channel   = '0;
        hit_ch.energy_ev = '0;
        hit_ch.time_ps   = '0;
        res_ch.ready     = 1'b0;
        window_ps        = WINDOW_RESET;
        threshold_ev     = THRESHOLD_RESET;
        clear_event();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty event, range and window edges, threshold edge
        write_reg(CFG_WINDOW, 32'd400000);
        write_reg(CFG_THRESHOLD, 32'd50000);
        push_eoe();
        push_hit(4'd12, 24'd1000, 40'd5);
        push_hit(4'd15, '1, '1);
        push_hit(4'd0, 24'd0, 40'd1000000);
        push_hit(4'd11, '1, 40'd1400000);
        push_hit(4'd5, 24'd777, 40'd1400001);
        push_hit(4'd5, 24'd50000, 40'd600000);
        push_hit(4'd6, 24'd50001, 40'd599999);
        push_hit(4'd7, 24'd50001, 40'd1000000);
        push_hit(4'd0, 24'd1, 40'd1000000);
        push_eoe();
        // Top of the time range, hits below the reference
        push_hit(4'd1, '1, '1);
        push_hit(4'd1, 24'd1, 40'hFF_FFF9_E57F);
        push_hit(4'd2, 24'd5, 40'd0);
        push_hit(4'd3, 24'd9, 40'hFF_FFF9_E57E);
        push_eoe();
        push_eoe();

        // Random phases over several settings
        random_phase(32'd0, 32'd0, PHASE_ITEMS);
        wait_drained();
        calm = 1'b1;
        random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, PHASE_ITEMS);
        wait_drained();
        calm = 1'b0;
        hold_req++;
        random_phase(32'($urandom), 32'($urandom_range(2000000)), PHASE_ITEMS);
        random_phase(32'd1000, 32'd100000, PHASE_ITEMS);
        random_phase(32'd400000, 32'd50000, PHASE_ITEMS);

        // Saturate one accumulator
        wait_drained();
        write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
        write_reg(CFG_THRESHOLD, 32'hFFFF_FFFE);
        for (int h = 0; h < 258; h++) push_hit(4'd4, '1, 40'h80_0000_0000);
        push_hit(4'd9, 24'd3, 40'h80_FFFF_FFFF);
        push_hit(4'd10, 24'd3, 40'h81_0000_0000);
        push_eoe();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_sums.size() != 0) errors++;
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cwes_pkg.sv
rtl/cwes_hit_if.sv
rtl/cwes_res_if.sv
rtl/cwes_ctrl.sv
rtl/cwes_dp.sv
rtl/coincidence_window_energy_summer_unit.sv
dv/tb_coincidence_window_energy_summer_unit.sv
